// File: sv/mfcsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfcsd_pkg
// shared types and constants of the mpeg audio frame chain sync detector
// ----------------------------------------------------------------------------
package mfcsd_pkg;

  // chain table geometry
  localparam int unsigned CHAIN_SLOTS = 16;
  localparam int unsigned SLOT_W      = $clog2(CHAIN_SLOTS);
  localparam int unsigned SCAN_W      = SLOT_W + 1;

  // field widths
  localparam int unsigned POS_W  = 32;
  localparam int unsigned CH_W   = 2;
  localparam int unsigned RATE_W = 16;
  localparam int unsigned FLEN_W = 12;
  localparam int unsigned CNT_W  = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX         = 4'hF;
  localparam logic [CNT_W-1:0] DEFAULT_MIN_CHAIN = 4'd5;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_MIN_CHAIN_LENGTH = 1'b0;  // register index in paddr[2]

  typedef struct packed {
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  expected;
    logic [CH_W-1:0]   channels;
    logic [RATE_W-1:0] rate;
    logic [CNT_W-1:0]  count;
  } chain_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_e;

endpackage : mfcsd_pkg
`default_nettype wire

// File: sv/mp3_frame_chain_sync_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mp3_frame_chain_sync_detector
// tracks chains of candidate mpeg audio headers and reports a locked stream
// ----------------------------------------------------------------------------
// usage
//   input channel: one candidate header per item (position, channels, rate,
//   frame length), positions rising. output channel: exactly one result item
//   per input item (found flag, chain start, next position, channels, rate,
//   overflow flag). both channels use valid/stall; an item moves on a rising
//   edge with valid high and stall low.
//   timing: after an item is taken, the chain memory is read slot by slot
//   through its single read port, one slot a cycle, with the write-back of
//   the previous slot in the same cycle. the result is loaded into the output
//   register at the end of the scan; the next item is taken once the block is
//   idle again, so the item rate is set by the scan over the memory port.
//   the output register parts the two sides: a new item is accepted while a
//   result still waits; if the receiver stalls, the block holds at the end
//   of the next scan until the output register is free.
//   reset clears the slot valid bits, the control state and the output valid;
//   min_chain_length returns to 5. the chain memory itself is not cleared.
//   the user writes min_chain_length over the apb port only while the block
//   is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module mp3_frame_chain_sync_detector
  import mfcsd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output logic      [PDATA_W-1:0]   prdata,
  output logic                      pready,
  // header items in
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [POS_W-1:0]     header_position_i,
  input  wire logic [CH_W-1:0]      channel_count_i,
  input  wire logic [RATE_W-1:0]    sample_rate_i,
  input  wire logic [FLEN_W-1:0]    frame_length_i,
  // result items out
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      found_o,
  output logic      [POS_W-1:0]     first_frame_position_o,
  output logic      [POS_W-1:0]     expected_next_position_o,
  output logic      [CH_W-1:0]      found_channels_o,
  output logic      [RATE_W-1:0]    found_rate_o,
  output logic                      table_overflow_o
);

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] min_len_q, min_len_d;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MIN_CHAIN_LENGTH);

  always_comb begin
    min_len_d = min_len_q;
    if (cfg_wr) begin
      min_len_d = pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MIN_CHAIN_LENGTH) begin
      prdata = {{(PDATA_W-CNT_W){1'b0}}, min_len_q};
    end
  end

  // --------------------------------------------------------------------------
  // control
  // --------------------------------------------------------------------------
  ctrl_state_e state_q, state_d;

  logic in_accept;
  logic rd_en;       // issue a memory read this cycle
  logic fin_go;      // output register free, close out the item
  logic scan_last;   // last slot is in the processing stage

  // item registers
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  next_q;
  logic [CH_W-1:0]   ch_q;
  logic [RATE_W-1:0] rate_q;

  // scan pipeline
  logic [SCAN_W-1:0] scan_q;
  logic              pv_q;     // read data belongs to a slot being scanned
  logic [SLOT_W-1:0] pidx_q;   // slot in the processing stage

  // per-item summary built during the scan
  logic              extended_q;
  logic              win_q;
  logic [POS_W-1:0]  win_start_q;
  logic              free_found_q;
  logic [SLOT_W-1:0] free_idx_q;

  // slot valid bits
  logic [CHAIN_SLOTS-1:0] valid_q;

  // output register
  logic              out_valid_q;
  logic              found_q;
  logic [POS_W-1:0]  first_pos_q;
  logic [POS_W-1:0]  exp_pos_q;
  logic [CH_W-1:0]   found_ch_q;
  logic [RATE_W-1:0] found_rate_q;
  logic              overflow_q;

  assign scan_last = pv_q && (pidx_q == SLOT_W'(CHAIN_SLOTS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    fin_go     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_SCAN: begin
        rd_en = (scan_q < SCAN_W'(CHAIN_SLOTS));
      end
      ST_FINISH: begin
        fin_go = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // chain memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  chain_entry_t      mem_q [CHAIN_SLOTS];
  chain_entry_t      rdata_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  chain_entry_t      mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[scan_q[SLOT_W-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // slot evaluation in the processing stage
  // --------------------------------------------------------------------------
  logic             slot_v;
  logic             ahead;
  logic             hit;
  logic             do_ext;
  logic             do_drop;
  logic             free_after;
  logic [CNT_W-1:0] new_cnt;
  logic             win_take;
  logic             open_new;

  always_comb begin
    slot_v     = valid_q[pidx_q];
    ahead      = rdata_q.expected > pos_q;
    hit        = (rdata_q.expected == pos_q) && (rdata_q.channels == ch_q)
                 && (rdata_q.rate == rate_q);
    do_ext     = pv_q && slot_v && hit;
    do_drop    = pv_q && slot_v && !ahead && !hit;
    free_after = pv_q && (!slot_v || do_drop);
    new_cnt    = (rdata_q.count == COUNT_MAX) ? COUNT_MAX : rdata_q.count + CNT_W'(1);
    // strict compare keeps the lowest slot on equal starts
    win_take   = do_ext && (new_cnt >= min_len_q)
                 && (!win_q || (rdata_q.start < win_start_q));
    open_new   = fin_go && !win_q && !extended_q && free_found_q;
  end

  // write port: extension during the scan, a new chain at the close
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pidx_q;
    mem_wdata = rdata_q;
    if (do_ext) begin
      mem_we             = 1'b1;
      mem_wdata.expected = next_q;
      mem_wdata.count    = new_cnt;
    end else if (open_new) begin
      mem_we             = 1'b1;
      mem_waddr          = free_idx_q;
      mem_wdata.start    = pos_q;
      mem_wdata.expected = next_q;
      mem_wdata.channels = ch_q;
      mem_wdata.rate     = rate_q;
      mem_wdata.count    = CNT_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      min_len_q    <= DEFAULT_MIN_CHAIN;
      scan_q       <= '0;
      pv_q         <= 1'b0;
      extended_q   <= 1'b0;
      win_q        <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      min_len_q <= min_len_d;
      pv_q      <= rd_en;

      if (in_accept) begin
        scan_q       <= '0;
        extended_q   <= 1'b0;
        win_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        if (rd_en) scan_q <= scan_q + SCAN_W'(1);
        if (do_ext) extended_q <= 1'b1;
        if (win_take) win_q <= 1'b1;
        if (free_after && !free_found_q) free_found_q <= 1'b1;
      end

      // slot valid bits
      if (fin_go && win_q) begin
        valid_q <= '0;
      end else if (open_new) begin
        valid_q[free_idx_q] <= 1'b1;
      end else if (do_drop) begin
        valid_q[pidx_q] <= 1'b0;
      end

      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pos_q  <= header_position_i;
      next_q <= header_position_i + POS_W'(frame_length_i);
      ch_q   <= channel_count_i;
      rate_q <= sample_rate_i;
    end
    if (rd_en) begin
      pidx_q <= scan_q[SLOT_W-1:0];
    end
    if (win_take) begin
      win_start_q <= rdata_q.start;
    end
    if (free_after && !free_found_q) begin
      free_idx_q <= pidx_q;
    end
    if (fin_go) begin
      // extended chains share the item's channels and rate and next position
      found_q      <= win_q;
      first_pos_q  <= win_q ? win_start_q : '0;
      exp_pos_q    <= win_q ? next_q : '0;
      found_ch_q   <= win_q ? ch_q : '0;
      found_rate_q <= win_q ? rate_q : '0;
      overflow_q   <= !win_q && !extended_q && !free_found_q;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign found_o                  = found_q;
  assign first_frame_position_o   = first_pos_q;
  assign expected_next_position_o = exp_pos_q;
  assign found_channels_o         = found_ch_q;
  assign found_rate_o             = found_rate_q;
  assign table_overflow_o         = overflow_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a result never reports both a lock and a lost chain
  a_found_excl_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && table_overflow_o))
    else $error("found and table_overflow both set");

  // a lock empties the whole table
  a_lock_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && win_q) |=> (valid_q == '0))
    else $error("table not cleared after lock");

  // write-back never hits the slot being read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && rd_en) |-> (mem_waddr != scan_q[SLOT_W-1:0]))
    else $error("read and write to the same slot");

  // only a live chain is extended
  a_ext_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q == ST_SCAN)) |-> valid_q[mem_waddr])
    else $error("write-back to an empty slot");

  // a result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule : mp3_frame_chain_sync_detector
`default_nettype wire
